// File: rtl/dlcp_pkg.sv
// ----------------------------------------------------------------------------
// dlcp_pkg
// Shared opcodes, vertex-format tables and sequencer states for the display
// list command processor.
// ----------------------------------------------------------------------------
package dlcp_pkg;

  // command opcodes, bits 31:24 of a command word
  localparam logic [7:0] OP_VADR   = 8'h01;
  localparam logic [7:0] OP_IADR   = 8'h02;
  localparam logic [7:0] OP_JUMP   = 8'h08;
  localparam logic [7:0] OP_CALL   = 8'h0A;
  localparam logic [7:0] OP_RET    = 8'h0B;
  localparam logic [7:0] OP_END    = 8'h0C;
  localparam logic [7:0] OP_FINISH = 8'h0F;
  localparam logic [7:0] OP_BASE   = 8'h10;
  localparam logic [7:0] OP_VTYPE  = 8'h12;
  localparam logic [7:0] OP_OFFADR = 8'h13;
  localparam logic [7:0] OP_ORIGIN = 8'h14;

  // input word kinds
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  localparam logic [31:0] WORD_ALIGN_MASK = 32'hFFFF_FFFC;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_VT1,
    ST_VT2,
    ST_VT3,
    ST_VT4
  } state_t;

  // element size in bytes for 2-bit component formats
  function automatic logic [2:0] elem_size(input logic [1:0] fmt);
    logic [2:0] s;
    case (fmt)
      2'd0:    s = 3'd0;
      2'd1:    s = 3'd1;
      2'd2:    s = 3'd2;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] elem_pad(input logic [1:0] fmt);
    logic [1:0] p;
    case (fmt)
      2'd2:    p = 2'd1;
      2'd3:    p = 2'd3;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  // colour format sizes
  function automatic logic [2:0] col_size(input logic [2:0] fmt);
    logic [2:0] s;
    case (fmt)
      3'd0:    s = 3'd0;
      3'd1:    s = 3'd1;
      3'd2:    s = 3'd1;
      3'd3:    s = 3'd1;
      3'd4:    s = 3'd2;
      3'd5:    s = 3'd2;
      3'd6:    s = 3'd2;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] col_pad(input logic [2:0] fmt);
    logic [1:0] p;
    case (fmt)
      3'd4:    p = 2'd1;
      3'd5:    p = 2'd1;
      3'd6:    p = 2'd1;
      3'd7:    p = 2'd3;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  // round up to the next multiple of pad + 1
  function automatic logic [7:0] round_up8(input logic [7:0] v, input logic [1:0] pad);
    logic [7:0] p;
    p = {6'd0, pad};
    return (v + p) & ~p;
  endfunction

  function automatic logic [9:0] round_up10(input logic [9:0] v, input logic [1:0] pad);
    logic [9:0] p;
    p = {8'd0, pad};
    return (v + p) & ~p;
  endfunction

endpackage

// File: rtl/dlcp_ram.sv
// ----------------------------------------------------------------------------
// dlcp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: rtl/display_list_command_processor_core.sv
// ----------------------------------------------------------------------------
// display_list_command_processor_core
// Display list front end: list pointer, call/return stack in RAM, address
// registers and a staged vertex-format decoder.
// ----------------------------------------------------------------------------
//
//  channel | ports                               | direction
//  --------+-------------------------------------+-------------------------
//  cfg     | cfg_valid/cfg_ready, stall address  | in, always ready
//  in      | in_valid/in_ready, func, word       | in, one word at a time
//  out     | out_valid/out_ready, list state     | out, one result per word
//
//  a word is taken in the idle state and executed in the exec state, a split
//  set by the registered read of the stack RAM; a vertex-type word walks
//  four more decode stages before its result is written
//  the result sits in the state registers; the next word may be taken while
//  it waits, but it is only executed once the result has been taken
//  synchronous active-low reset clears all control state; the stack RAM
//  holds no reset value and needs no clearing pass
//
module display_list_command_processor_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // stall address register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_stall_address,
  // command words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_command_word,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_fetch_address,
  output logic        out_list_done,
  output logic [31:0] out_vertex_address,
  output logic [31:0] out_index_address,
  output logic [9:0]  out_vertex_size,
  output logic [6:0]  out_morph_stride,
  output logic [6:0]  out_texture_offset,
  output logic [6:0]  out_color_offset,
  output logic [6:0]  out_normal_offset,
  output logic [6:0]  out_position_offset,
  output logic [2:0]  out_alignment_size,
  output logic        out_stack_fault
);
  import dlcp_pkg::*;

  // stack level counts up to the depth itself
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int ADR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

  state_t state_r, state_nxt;

  logic [31:0] stall_r;

  // captured word
  logic        func_r;
  logic [31:0] word_r;

  // list state
  logic [31:0] pc_r, pc_nxt;
  logic [7:0]  base_r, base_nxt;
  logic [31:0] off_r, off_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic        end_r, end_nxt;
  logic        fin_r, fin_nxt;
  logic        active_r, active_nxt;
  logic [31:0] vptr_r, vptr_nxt;
  logic [31:0] iptr_r, iptr_nxt;

  // vertex layout
  logic [9:0]  vsize_r, vsize_nxt;
  logic [6:0]  mstride_r, mstride_nxt;
  logic [6:0]  toff_r, coff_r, noff_r, poff_r;
  logic [2:0]  align_r;

  // decode pipeline
  logic [7:0]  vt_toff_r, vt_coff_r, vt_sz_r;
  logic [7:0]  vt_noff_r, vt_poff_r, vt_one_r;
  logic [2:0]  vt_align_r;
  logic [9:0]  vt_sz10_r;

  logic        out_valid_r;
  logic        fault_r, fault_nxt;

  // stack RAM: return address in the upper half, saved offset in the lower
  logic              push;
  logic [LVL_W-1:0]  top_level;
  logic [63:0]       stack_rd;

  logic        out_free;
  logic        is_vtype;
  logic        commit;
  logic [7:0]  op;
  logic [23:0] arg;
  logic [31:0] eff;
  logic [31:0] pc_inc;
  logic        done;

  // decode fields
  logic [1:0] f_tex, f_nrm, f_pos, f_wgt;
  logic [2:0] f_col;
  logic [3:0] f_wcount, f_mcount;
  logic [7:0] vt1_w, vt1_toff, vt1_sz1, vt1_coff, vt1_sz2;
  logic [7:0] vt2_noff, vt2_sz3, vt2_poff, vt2_one;
  logic [2:0] vt2_align;
  logic [1:0] align_pad;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  assign op     = word_r[31:24];
  assign arg    = word_r[23:0];
  assign eff    = {base_r, arg} + off_r;
  assign pc_inc = pc_r + 32'd4;

  assign is_vtype = (func_r == FUNC_COMMAND) && active_r && (op == OP_VTYPE);
  assign commit   = ((state_r == ST_EXEC) && !is_vtype && out_free) ||
                    ((state_r == ST_VT4) && out_free);

  // ---------------------------------------------------------------- stack
  // read address always tracks the top entry; level only moves on commit
  // and the next word is only executed after the idle state, so no forwarding
  assign top_level = level_r - LVL_W'(1);

  dlcp_ram #(
    .WIDTH (64),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (commit && push),
    .wr_addr (level_r[ADR_W-1:0]),
    .wr_data ({pc_inc, off_r}),
    .rd_addr (top_level[ADR_W-1:0]),
    .rd_data (stack_rd)
  );

  // ---------------------------------------------------------------- execute
  always_comb begin
    pc_nxt     = pc_r;
    base_nxt   = base_r;
    off_nxt    = off_r;
    level_nxt  = level_r;
    end_nxt    = end_r;
    fin_nxt    = fin_r;
    active_nxt = active_r;
    vptr_nxt   = vptr_r;
    iptr_nxt   = iptr_r;
    fault_nxt  = 1'b0;
    push       = 1'b0;
    done       = 1'b0;

    if (func_r == FUNC_START) begin
      // start or restart a list
      pc_nxt     = word_r;
      end_nxt    = 1'b0;
      fin_nxt    = 1'b0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      pc_nxt = pc_inc;
      case (op)
        OP_JUMP: begin
          pc_nxt = eff & WORD_ALIGN_MASK;
        end
        OP_CALL: begin
          if (level_r >= LVL_FULL) begin
            fault_nxt = 1'b1;
          end else begin
            push      = 1'b1;
            level_nxt = level_r + LVL_W'(1);
            pc_nxt    = eff & WORD_ALIGN_MASK;
          end
        end
        OP_RET: begin
          if (level_r == '0) begin
            fault_nxt = 1'b1;
          end else begin
            level_nxt = top_level;
            pc_nxt    = stack_rd[63:32];
            off_nxt   = stack_rd[31:0];
          end
        end
        OP_BASE:   base_nxt = arg[23:16];
        OP_OFFADR: off_nxt  = {arg, 8'd0};
        OP_ORIGIN: off_nxt  = pc_r;          // address of this word
        OP_VADR:   vptr_nxt = eff;
        OP_IADR:   iptr_nxt = eff;
        OP_END:    end_nxt  = 1'b1;
        OP_FINISH: fin_nxt  = 1'b1;
        default: ;
      endcase
    end

    // end of list: end and finish both seen, or stall address reached
    // while end is still outstanding
    if (active_nxt) begin
      done = end_nxt ? fin_nxt : (pc_nxt >= stall_r);
    end
    if (done) begin
      active_nxt = 1'b0;
      end_nxt    = 1'b0;
      fin_nxt    = 1'b0;
    end
  end

  // ---------------------------------------------------------------- vertex decode
  assign f_tex    = arg[1:0];
  assign f_col    = arg[4:2];
  assign f_nrm    = arg[6:5];
  assign f_pos    = arg[8:7];
  assign f_wgt    = arg[10:9];
  assign f_wcount = {1'b0, arg[16:14]} + 4'd1;
  assign f_mcount = {1'b0, arg[20:18]} + 4'd1;

  // stage 1: weights, texture and colour
  assign vt1_w    = 8'(elem_size(f_wgt)) * 8'(f_wcount);
  assign vt1_toff = round_up8(vt1_w, elem_pad(f_tex));
  assign vt1_sz1  = vt1_toff + 8'({elem_size(f_tex), 1'b0});
  assign vt1_coff = round_up8(vt1_sz1, col_pad(f_col));
  assign vt1_sz2  = vt1_coff + 8'(col_size(f_col));

  // stage 2: normal and position, largest element
  assign vt2_noff = round_up8(vt_sz_r, elem_pad(f_nrm));
  assign vt2_sz3  = vt2_noff + 8'(elem_size(f_nrm)) * 8'd3;
  assign vt2_poff = round_up8(vt2_sz3, elem_pad(f_pos));
  assign vt2_one  = vt2_poff + 8'(elem_size(f_pos)) * 8'd3;

  always_comb begin
    vt2_align = elem_size(f_wgt);
    if (col_size(f_col) > vt2_align)  vt2_align = col_size(f_col);
    if (elem_size(f_nrm) > vt2_align) vt2_align = elem_size(f_nrm);
    if (elem_size(f_tex) > vt2_align) vt2_align = elem_size(f_tex);
    if (elem_size(f_pos) > vt2_align) vt2_align = elem_size(f_pos);
  end

  // stage 4: pad whole vertex and morph stride to the alignment
  assign align_pad = 2'(vt_align_r - 3'd1);

  always_comb begin
    vsize_nxt   = vt_sz10_r;
    mstride_nxt = vt_one_r[6:0];
    if (vt_align_r != 3'd0) begin
      vsize_nxt   = round_up10(vt_sz10_r, align_pad);
      mstride_nxt = 7'(round_up8(vt_one_r, align_pad));
    end
  end

  always_ff @(posedge clk) begin
    vt_toff_r  <= vt1_toff;
    vt_coff_r  <= vt1_coff;
    vt_sz_r    <= vt1_sz2;
    vt_noff_r  <= vt2_noff;
    vt_poff_r  <= vt2_poff;
    vt_one_r   <= vt2_one;
    vt_align_r <= vt2_align;
    // stage 3: morph copies
    vt_sz10_r  <= 10'(vt_one_r) * 10'(f_mcount);
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (is_vtype) begin
          state_nxt = ST_VT1;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_VT1:  state_nxt = ST_VT2;
      ST_VT2:  state_nxt = ST_VT3;
      ST_VT3:  state_nxt = ST_VT4;
      ST_VT4:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      word_r <= in_command_word;
    end
  end

  // architectural state: stall address on cfg, the rest updated on commit only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_r     <= '0;
      pc_r        <= '0;
      base_r      <= '0;
      off_r       <= '0;
      level_r     <= '0;
      end_r       <= 1'b0;
      fin_r       <= 1'b0;
      active_r    <= 1'b0;
      vptr_r      <= '0;
      iptr_r      <= '0;
      vsize_r     <= '0;
      mstride_r   <= '0;
      toff_r      <= '0;
      coff_r      <= '0;
      noff_r      <= '0;
      poff_r      <= '0;
      align_r     <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stall_r <= cfg_stall_address;
      end
      if (commit) begin
        pc_r     <= pc_nxt;
        base_r   <= base_nxt;
        off_r    <= off_nxt;
        level_r  <= level_nxt;
        end_r    <= end_nxt;
        fin_r    <= fin_nxt;
        active_r <= active_nxt;
        vptr_r   <= vptr_nxt;
        iptr_r   <= iptr_nxt;
        fault_r  <= fault_nxt;
      end
      if (commit && (state_r == ST_VT4)) begin
        vsize_r   <= vsize_nxt;
        mstride_r <= mstride_nxt;
        toff_r    <= vt_toff_r[6:0];
        coff_r    <= vt_coff_r[6:0];
        noff_r    <= vt_noff_r[6:0];
        poff_r    <= vt_poff_r[6:0];
        align_r   <= vt_align_r;
      end
      out_valid_r <= commit || (out_valid_r && !out_ready);
    end
  end

  // ---------------------------------------------------------------- results
  // state only changes on a commit, which waits until the last result is
  // gone, so the state registers double as the result word
  assign out_valid           = out_valid_r;
  assign out_fetch_address   = pc_r;
  assign out_list_done       = !active_r;
  assign out_vertex_address  = vptr_r;
  assign out_index_address   = iptr_r;
  assign out_vertex_size     = vsize_r;
  assign out_morph_stride    = mstride_r;
  assign out_texture_offset  = toff_r;
  assign out_color_offset    = coff_r;
  assign out_normal_offset   = noff_r;
  assign out_position_offset = poff_r;
  assign out_alignment_size  = align_r;
  assign out_stack_fault     = fault_r;

endmodule

// File: rtl/dlcp_checker.sv
// ----------------------------------------------------------------------------
// dlcp_checker
// Port-level checks on the display list command processor, bound to the core.
// ----------------------------------------------------------------------------
module dlcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_fetch_address,
  input logic        out_list_done,
  input logic        out_stack_fault,
  input logic [9:0]  out_vertex_size,
  input logic [6:0]  out_morph_stride,
  input logic [2:0]  out_alignment_size
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fetch_address) &&
      $stable(out_list_done) && $stable(out_stack_fault))
    else $error("result word changed while stalled");

  // a result only goes away when taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result word dropped");

  // one word in flight: nothing is taken right after a word
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while previous one executes");

  // alignment is a real element size and at four bytes the sizes honour it
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alignment_size == 3'd0 || out_alignment_size == 3'd1 ||
      out_alignment_size == 3'd2 ||
      (out_alignment_size == 3'd4 && out_vertex_size[1:0] == 2'd0 &&
       out_morph_stride[1:0] == 2'd0)))
    else $error("vertex alignment inconsistent");

endmodule

bind display_list_command_processor_core dlcp_checker u_dlcp_checker (.*);
